FILE: src/pal2rgb_pkg.sv
// Shared types, constants and helpers for the palette index to packed RGB block.
// No dependencies; imported by pal2rgb_chan and palette_index_to_packed_rgb.
package pal2rgb_pkg;

  localparam int unsigned PaletteEntriesDef = 256;
  localparam int unsigned AddrW             = 4;
  localparam int unsigned DataW             = 32;

  localparam logic [7:0] RsvdLowEnd   = 8'd10;   // entries below this are reserved
  localparam logic [7:0] RsvdHighBase = 8'd246;  // entries from this up are reserved
  localparam logic [7:0] IdxBlack     = 8'd0;
  localparam logic [7:0] IdxWhite     = 8'd255;

  localparam logic FuncWrite   = 1'b0;
  localparam logic FuncConvert = 1'b1;

  localparam logic [1:0] RegRedMask   = 2'd0;
  localparam logic [1:0] RegGreenMask = 2'd1;
  localparam logic [1:0] RegBlueMask  = 2'd2;

  localparam logic [31:0] RedMaskRst   = 32'h00FF_0000;
  localparam logic [31:0] GreenMaskRst = 32'h0000_FF00;
  localparam logic [31:0] BlueMaskRst  = 32'h0000_00FF;

  // Channel layout taken from a mask: position of lowest set bit and field width.
  typedef struct packed {
    logic [4:0] shift;
    logic [5:0] bits;
  } chan_fmt_t;

  function automatic chan_fmt_t fmt_of_mask(logic [31:0] mask);
    chan_fmt_t  f;
    logic [4:0] lo;
    logic [4:0] hi;
    lo = 5'd0;
    hi = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (mask[i]) lo = 5'(i);
    end
    for (int i = 0; i < 32; i++) begin
      if (mask[i]) hi = 5'(i);
    end
    f.shift = lo;
    f.bits  = (mask == '0) ? 6'd0 : 6'({1'b0, hi} - {1'b0, lo} + 6'd1);
    return f;
  endfunction

endpackage

FILE: src/palette_index_to_packed_rgb.sv
// A convert request's lookup is registered in s1, then its pixel in the output register.
// One request per clock unless stalled; the single-port palette RAM reads once a cycle.
// Writes produce no output and are visible to a convert in the next cycle.
// Reset: palette valid bits clear at once (unwritten non-white entries read zero), masks
// return to their defaults; no clearing pass, requests accepted right after reset.
module palette_index_to_packed_rgb #(
  parameter int unsigned PALETTE_ENTRIES = pal2rgb_pkg::PaletteEntriesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pal2rgb_pkg::AddrW-1:0] paddr,
  input  logic [pal2rgb_pkg::DataW-1:0] pwdata,
  output logic [pal2rgb_pkg::DataW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [7:0]                   palette_index_i,
  input  logic [7:0]                   color_red_i,
  input  logic [7:0]                   color_green_i,
  input  logic [7:0]                   color_blue_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  pixel_word_o
);
  import pal2rgb_pkg::*;

  localparam int unsigned IdxW = $clog2(PALETTE_ENTRIES);

  // configuration registers
  logic [31:0] red_mask_q, green_mask_q, blue_mask_q;
  chan_fmt_t   red_fmt_q, green_fmt_q, blue_fmt_q;
  logic        cfg_wr;
  logic [1:0]  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_sel)
      RegRedMask:   prdata = red_mask_q;
      RegGreenMask: prdata = green_mask_q;
      RegBlueMask:  prdata = blue_mask_q;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_mask_q   <= RedMaskRst;
      green_mask_q <= GreenMaskRst;
      blue_mask_q  <= BlueMaskRst;
      red_fmt_q    <= fmt_of_mask(RedMaskRst);
      green_fmt_q  <= fmt_of_mask(GreenMaskRst);
      blue_fmt_q   <= fmt_of_mask(BlueMaskRst);
    end else begin
      if (cfg_wr) begin
        case (cfg_sel)
          RegRedMask:   red_mask_q   <= pwdata;
          RegGreenMask: green_mask_q <= pwdata;
          RegBlueMask:  blue_mask_q  <= pwdata;
          default: ;
        endcase
      end
      // layout is registered from the masks, off the pixel path
      red_fmt_q   <= fmt_of_mask(red_mask_q);
      green_fmt_q <= fmt_of_mask(green_mask_q);
      blue_fmt_q  <= fmt_of_mask(blue_mask_q);
    end
  end

  // request channel and pipeline control
  logic            in_acc;
  logic            s1_valid_q;
  logic            s1_move;
  logic            out_free;
  logic            out_valid_q;
  logic [31:0]     pixel_q;
  logic [IdxW-1:0] idx;
  logic            reserved;
  logic            wr_en;
  logic [23:0]     wdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign idx      = palette_index_i[IdxW-1:0];
  assign reserved = (palette_index_i < RsvdLowEnd) || (palette_index_i >= RsvdHighBase);
  assign wr_en    = in_acc && (func_i == FuncWrite);
  assign wdata    = reserved ? {palette_index_i, 16'h0000}
                             : {color_red_i, color_green_i, color_blue_i};

  // palette RAM, one access per cycle, registered read
  logic [23:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] written_q;
  logic [23:0]                rdata_q;
  logic                       s1_hit_q;
  logic                       s1_black_q;
  logic                       s1_white_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= wdata;
    end
    if (in_acc) begin
      rdata_q    <= mem[idx];
      s1_black_q <= (palette_index_i == IdxBlack);
      s1_white_q <= (palette_index_i == IdxWhite);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      s1_hit_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written_q[idx] <= 1'b1;
      end
      if (in_acc) begin
        s1_hit_q   <= written_q[idx];
        s1_valid_q <= (func_i == FuncConvert);
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // color select and packing
  logic [23:0] rgb;
  logic [31:0] red_word, green_word, blue_word;

  always_comb begin
    if (s1_black_q) begin
      rgb = '0;
    end else if (s1_white_q) begin
      rgb = '1;
    end else if (s1_hit_q) begin
      rgb = rdata_q;
    end else begin
      rgb = '0;
    end
  end

  pal2rgb_chan u_red (
    .c_i    (rgb[23:16]),
    .mask_i (red_mask_q),
    .fmt_i  (red_fmt_q),
    .word_o (red_word)
  );

  pal2rgb_chan u_green (
    .c_i    (rgb[15:8]),
    .mask_i (green_mask_q),
    .fmt_i  (green_fmt_q),
    .word_o (green_word)
  );

  pal2rgb_chan u_blue (
    .c_i    (rgb[7:0]),
    .mask_i (blue_mask_q),
    .fmt_i  (blue_fmt_q),
    .word_o (blue_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      pixel_q <= red_word | green_word | blue_word;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_word_o = pixel_q;

`ifndef SYNTH
  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without a blocked result");

  a_convert_enters_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (func_i == FuncConvert) |=> s1_valid_q)
    else $error("accepted convert did not reach the lookup stage");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (func_i == FuncWrite) |=> !s1_valid_q)
    else $error("palette write produced a result");

  a_s1_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("lookup result lost before the output register");
`endif

endmodule

FILE: src/pal2rgb_chan.sv
// One channel of the pixel packer: scales an 8-bit color to the mask's field
// width and places it under the mask. Depends on pal2rgb_pkg.
module pal2rgb_chan (
  input  logic [7:0]              c_i,
  input  logic [31:0]             mask_i,
  input  pal2rgb_pkg::chan_fmt_t  fmt_i,
  output logic [31:0]             word_o
);
  import pal2rgb_pkg::*;

  logic [31:0] pattern;
  logic [31:0] top_bits;
  logic [15:0] rot_wide;
  logic [7:0]  rem;
  logic [31:0] scaled;

  // c/255 in base 256 is the byte c repeated, so c*2^b/255 floors to the
  // top b bits of that pattern; the next byte of the pattern is the remainder.
  assign pattern  = {c_i, c_i, c_i, c_i};
  assign top_bits = pattern >> (6'd32 - fmt_i.bits);
  assign rot_wide = {c_i, c_i} << fmt_i.bits[2:0];
  assign rem      = rot_wide[15:8];

  // Subtracting c from the numerator borrows one when the remainder is short.
  assign scaled = (rem < c_i) ? top_bits - 32'd1 : top_bits;
  assign word_o = (scaled << fmt_i.shift) & mask_i;

endmodule
